// File: rtl/core/irbsf_pkg.sv
// ----------------------------------------------------------------------------
// irbsf_pkg
// Shared constants, types and receiver map tables for the beacon slot
// bearing finder.
// ----------------------------------------------------------------------------
`default_nettype none

package irbsf_pkg;

  // frame geometry
  localparam int RECEIVERS   = 16;
  localparam int FRAME_SLOTS = 48;
  localparam int RING_LEN    = RECEIVERS + RECEIVERS / 2;
  localparam int NGROUPS     = (FRAME_SLOTS + RECEIVERS - 1) / RECEIVERS;

  // widths
  localparam int ID_W      = 8;
  localparam int SLOT_W    = $clog2(FRAME_SLOTS);
  localparam int RPOS_W    = (RECEIVERS > 1) ? $clog2(RECEIVERS) : 1;
  localparam int RING_AW   = $clog2(RING_LEN);
  localparam int CNT_W     = $clog2(RING_LEN + 1);
  localparam int GRP_W     = $clog2(NGROUPS + 1);
  localparam int RUN_W     = $clog2(RING_LEN + 1);
  localparam int POS_W     = 8;
  localparam int MASK_W    = 16;
  localparam int CFG_IDX_W = 1;

  // register reset values
  localparam logic [ID_W-1:0] ID_A_RESET = 8'h44;
  localparam logic [ID_W-1:0] ID_B_RESET = 8'h25;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ID_A = 1'b0,
    REG_ID_B = 1'b1
  } cfg_reg_t;

  // controller to datapath commands
  typedef struct packed {
    logic               take;
    logic               fr_rd;
    logic [CNT_W-1:0]   fr_idx;
    logic               ring_wr;
    logic [RING_AW-1:0] wr_idx;
    logic               ring_rd;
    logic [RING_AW-1:0] rd_idx;
    logic               prime;
    logic               fill;
    logic [RING_AW-1:0] fill_idx;
    logic               close;
    logic               load_res;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic group_end;
    logic out_free;
  } sts_t;

  // slot position to receiver number
  function automatic logic [3:0] slot_receiver(input logic [3:0] idx);
    logic [3:0] r;
    case (idx)
      4'd0:    r = 4'd13;
      4'd1:    r = 4'd9;
      4'd2:    r = 4'd5;
      4'd3:    r = 4'd1;
      4'd4:    r = 4'd12;
      4'd5:    r = 4'd8;
      4'd6:    r = 4'd4;
      4'd7:    r = 4'd0;
      4'd8:    r = 4'd15;
      4'd9:    r = 4'd11;
      4'd10:   r = 4'd7;
      4'd11:   r = 4'd3;
      4'd12:   r = 4'd14;
      4'd13:   r = 4'd10;
      4'd14:   r = 4'd6;
      default: r = 4'd2;
    endcase
    return r;
  endfunction

  // receiver number to analog channel
  function automatic logic [2:0] receiver_channel(input logic [3:0] rcv);
    logic [2:0] c;
    case (rcv)
      4'd0:    c = 3'd2;
      4'd1:    c = 3'd5;
      4'd2:    c = 3'd3;
      4'd3:    c = 3'd2;
      4'd4:    c = 3'd7;
      4'd5:    c = 3'd1;
      4'd6:    c = 3'd7;
      4'd7:    c = 3'd1;
      4'd8:    c = 3'd6;
      4'd9:    c = 3'd0;
      4'd10:   c = 3'd6;
      4'd11:   c = 3'd0;
      4'd12:   c = 3'd4;
      4'd13:   c = 3'd3;
      4'd14:   c = 3'd4;
      default: c = 3'd5;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/ir_beacon_slot_bearing_finder_top.sv
// ----------------------------------------------------------------------------
// ir_beacon_slot_bearing_finder_top
// Stores beacon ids per time slot, steers the receiver mux and, at the end
// of each receiver group, fills gaps and reports the largest run's bearing.
//
//   channel  dir  handshake           payload
//   in       in   in_valid/in_stall   in_received_byte
//   out      out  out_valid/out_stall mux select, group results, match mask
//   cfg      in   cfg_we              cfg_index, cfg_data (beacon ids)
//
// a slot that does not close a group is taken and its word is registered
// at the output on the same edge
// a group-closing slot runs the copy, prime, fill and close states and then
// the result state; in_stall is high through them, and the next word is
// taken once the result is loaded
// the frame store and work ring are memories with a single read port each
// reset is synchronous, active low; no memory clearing pass is run
// in_stall is high while a group pass runs or a result waits on out_stall
// ----------------------------------------------------------------------------
`default_nettype none

module ir_beacon_slot_bearing_finder_top
  import irbsf_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           in_received_byte,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_mux_bank,
  output logic [2:0]                out_mux_channel,
  output logic                      out_result_valid,
  output logic [1:0]                out_group_index,
  output logic [4:0]                out_cluster_size,
  output logic [7:0]                out_cluster_beacon,
  output logic [4:0]                out_bearing,
  output logic [15:0]               out_match_mask,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data
);

  cmd_t cmd;
  sts_t sts;

  // sequencer
  irbsf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  irbsf_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_received_byte   (in_received_byte),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_mux_bank       (out_mux_bank),
    .out_mux_channel    (out_mux_channel),
    .out_result_valid   (out_result_valid),
    .out_group_index    (out_group_index),
    .out_cluster_size   (out_cluster_size),
    .out_cluster_beacon (out_cluster_beacon),
    .out_bearing        (out_bearing),
    .out_match_mask     (out_match_mask)
  );

endmodule

`default_nettype wire

// File: rtl/core/irbsf_ctrl.sv
// ----------------------------------------------------------------------------
// irbsf_ctrl
// Sequencer for the group pass: frame copy, gap fill with run scan, final
// run close and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module irbsf_ctrl
  import irbsf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COPY,
    ST_PRIME0,
    ST_PRIME1,
    ST_FILL,
    ST_CLOSE,
    ST_RESULT
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W:0]   rd_ahead;

  // input word is taken only between group passes
  assign in_stall = !((state_r == ST_IDLE) && sts.out_free);

  // read address two entries ahead of the fill position
  assign rd_ahead = (CNT_W + 1)'(count_r) + (CNT_W + 1)'(2);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.take = in_valid && !in_stall;
        if (cmd.take && sts.group_end) begin
          state_nxt = ST_COPY;
          count_nxt = '0;
        end
      end
      ST_COPY: begin
        cmd.fr_rd   = (count_r < CNT_W'(RING_LEN));
        cmd.fr_idx  = count_r;
        cmd.ring_wr = (count_r != '0);
        cmd.wr_idx  = RING_AW'(count_r - CNT_W'(1));
        if (count_r == CNT_W'(RING_LEN)) begin
          state_nxt = ST_PRIME0;
          count_nxt = '0;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      ST_PRIME0: begin
        cmd.ring_rd = 1'b1;
        cmd.rd_idx  = RING_AW'(0);
        state_nxt   = ST_PRIME1;
      end
      ST_PRIME1: begin
        cmd.ring_rd = 1'b1;
        cmd.rd_idx  = RING_AW'(1);
        cmd.prime   = 1'b1;
        state_nxt   = ST_FILL;
        count_nxt   = '0;
      end
      ST_FILL: begin
        cmd.fill     = 1'b1;
        cmd.fill_idx = RING_AW'(count_r);
        cmd.ring_rd  = (rd_ahead < (CNT_W + 1)'(RING_LEN));
        cmd.rd_idx   = RING_AW'(rd_ahead);
        if (count_r == CNT_W'(RING_LEN - 1)) begin
          state_nxt = ST_CLOSE;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      ST_CLOSE: begin
        cmd.close = 1'b1;
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts.out_free) begin
          cmd.load_res = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/irbsf_dp.sv
// ----------------------------------------------------------------------------
// irbsf_dp
// Datapath: id registers, slot counters, frame store, work ring, gap fill,
// run scan, match mask and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module irbsf_dp
  import irbsf_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cmd_t                 cmd,
  output sts_t                      sts,
  input  wire logic [ID_W-1:0]      in_received_byte,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ID_W-1:0]      cfg_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_mux_bank,
  output logic [2:0]                out_mux_channel,
  output logic                      out_result_valid,
  output logic [1:0]                out_group_index,
  output logic [4:0]                out_cluster_size,
  output logic [7:0]                out_cluster_beacon,
  output logic [4:0]                out_bearing,
  output logic [MASK_W-1:0]         out_match_mask
);

  // configuration
  logic [ID_W-1:0] id_a_r, id_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_a_r <= ID_A_RESET;
      id_b_r <= ID_B_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ID_A: id_a_r <= cfg_data;
        REG_ID_B: id_b_r <= cfg_data;
        default:  ;
      endcase
    end
  end

  // slot counters
  logic [SLOT_W-1:0] slot_r, base_r, proc_base_r, slot_inc;
  logic [RPOS_W-1:0] rpos_r, rpos_inc;
  logic [GRP_W-1:0]  grp_r, proc_grp_r;
  logic              wrap;

  assign wrap     = (slot_r == SLOT_W'(FRAME_SLOTS - 1));
  assign slot_inc = wrap ? '0 : slot_r + SLOT_W'(1);
  assign rpos_inc = (wrap || rpos_r == RPOS_W'(RECEIVERS - 1)) ? '0 : rpos_r + RPOS_W'(1);

  assign sts.group_end = (rpos_inc == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      rpos_r <= '0;
      grp_r  <= '0;
      base_r <= '0;
    end else if (cmd.take) begin
      slot_r <= slot_inc;
      rpos_r <= rpos_inc;
      if (sts.group_end) begin
        grp_r  <= wrap ? '0 : grp_r + GRP_W'(1);
        base_r <= slot_inc;
      end
    end
  end

  // group being processed
  always_ff @(posedge clk) begin
    if (cmd.take && sts.group_end) begin
      proc_grp_r  <= grp_r;
      proc_base_r <= base_r;
    end
  end

  // receiver mux select for the next slot
  logic [3:0] rcv;
  logic       bank_now;
  logic [2:0] chan_now;
  logic       pend_bank_r;
  logic [2:0] pend_chan_r;

  assign rcv      = slot_receiver(4'(rpos_inc));
  assign bank_now = ~rcv[1];
  assign chan_now = receiver_channel(rcv);

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      pend_bank_r <= bank_now;
      pend_chan_r <= chan_now;
    end
  end

  // frame store, one word per slot
  logic [ID_W-1:0]   frame_mem [FRAME_SLOTS];
  logic [ID_W-1:0]   keep_byte;
  logic [CNT_W-1:0]  fr_off;
  logic [SLOT_W:0]   fr_addr;
  logic [ID_W-1:0]   fr_q_r;
  logic              fr_zero_r;
  logic [ID_W-1:0]   copy_data;

  assign keep_byte = (in_received_byte != '0 &&
                      (in_received_byte == id_a_r || in_received_byte == id_b_r))
                     ? in_received_byte : '0;
  assign fr_off    = (cmd.fr_idx < CNT_W'(RECEIVERS)) ? cmd.fr_idx
                                                      : cmd.fr_idx - CNT_W'(RECEIVERS);
  assign fr_addr   = (SLOT_W + 1)'(proc_base_r) + (SLOT_W + 1)'(fr_off);
  assign copy_data = fr_zero_r ? '0 : fr_q_r;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      frame_mem[slot_r] <= keep_byte;
    end
    if (cmd.fr_rd) begin
      fr_q_r    <= frame_mem[fr_addr[SLOT_W-1:0]];
      fr_zero_r <= (fr_addr >= (SLOT_W + 1)'(FRAME_SLOTS));
    end
  end

  // work ring
  logic [ID_W-1:0]    ring_mem [RING_LEN];
  logic [ID_W-1:0]    rd_q_r;
  logic               ring_we;
  logic [RING_AW-1:0] ring_waddr;
  logic [ID_W-1:0]    ring_wdata;
  logic [ID_W-1:0]    fin;

  assign ring_we    = cmd.ring_wr || cmd.fill;
  assign ring_waddr = cmd.fill ? cmd.fill_idx : cmd.wr_idx;
  assign ring_wdata = cmd.fill ? fin : copy_data;

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[ring_waddr] <= ring_wdata;
    end
    if (cmd.ring_rd) begin
      rd_q_r <= ring_mem[cmd.rd_idx];
    end
  end

  // gap fill window: updated previous, original current, fetched next
  logic [ID_W-1:0] prev_r, cur_r, mid_r;
  logic [ID_W-1:0] next_val;

  assign next_val = (cmd.fill_idx == RING_AW'(RING_LEN - 1)) ? mid_r : rd_q_r;
  assign fin      = (prev_r == next_val) ? prev_r : cur_r;

  always_ff @(posedge clk) begin
    if (cmd.ring_wr && cmd.wr_idx == RING_AW'(RECEIVERS - 1)) begin
      prev_r <= copy_data;
    end else if (cmd.fill) begin
      prev_r <= fin;
    end
    if (cmd.prime || cmd.fill) begin
      cur_r <= rd_q_r;
    end
    if (cmd.fill && cmd.fill_idx == RING_AW'(RECEIVERS / 2)) begin
      mid_r <= fin;
    end
  end

  // run scan over the filled entries
  logic [RUN_W-1:0]  size_r, size_nxt, best_r, best_nxt;
  logic [ID_W-1:0]   id_r, id_nxt, bid_r, bid_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [CNT_W-1:0]  close_at;
  logic              closing;

  assign close_at = cmd.fill ? CNT_W'(cmd.fill_idx) : CNT_W'(RING_LEN);

  always_comb begin
    size_nxt = size_r;
    id_nxt   = id_r;
    best_nxt = best_r;
    bid_nxt  = bid_r;
    pos_nxt  = pos_r;
    closing  = 1'b0;
    if (cmd.take) begin
      size_nxt = '0;
      id_nxt   = '0;
      best_nxt = '0;
      bid_nxt  = '0;
      pos_nxt  = '0;
    end else if (cmd.fill) begin
      if (fin != '0) begin
        if (size_r == '0) begin
          size_nxt = RUN_W'(1);
          id_nxt   = fin;
        end else if (id_r == fin) begin
          size_nxt = size_r + RUN_W'(1);
        end else begin
          closing  = 1'b1;
          size_nxt = RUN_W'(1);
          id_nxt   = fin;
        end
      end else if (size_r != '0) begin
        closing  = 1'b1;
        size_nxt = '0;
        id_nxt   = '0;
      end
    end else if (cmd.close) begin
      closing = 1'b1;
    end
    if (closing && size_r > best_r) begin
      best_nxt = size_r;
      bid_nxt  = id_r;
      pos_nxt  = POS_W'({close_at, 1'b0}) - POS_W'(size_r);
    end
  end

  always_ff @(posedge clk) begin
    size_r <= size_nxt;
    id_r   <= id_nxt;
    best_r <= best_nxt;
    bid_r  <= bid_nxt;
    pos_r  <= pos_nxt;
  end

  // per-receiver match mask
  logic [MASK_W-1:0] mask_r;
  logic [ID_W-1:0]   want;
  logic              mask_on;

  assign mask_on = (proc_grp_r == GRP_W'(0)) || (proc_grp_r == GRP_W'(1));
  assign want    = (proc_grp_r == GRP_W'(0)) ? id_a_r : id_b_r;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      mask_r <= '0;
    end else if (cmd.fill && mask_on && fin == want &&
                 int'(cmd.fill_idx) < MASK_W && int'(cmd.fill_idx) < RECEIVERS) begin
      mask_r <= mask_r | (MASK_W'(1) << cmd.fill_idx);
    end
  end

  // bearing from run centre position
  logic [POS_W-1:0] brg_a, brg_b, brg_c;

  assign brg_a = pos_r - POS_W'(1);
  assign brg_b = (brg_a >= POS_W'(2 * RECEIVERS)) ? brg_a - POS_W'(2 * RECEIVERS) : brg_a;
  assign brg_c = (brg_b > POS_W'(2 * RECEIVERS)) ? '0 : brg_b;

  // output register
  logic       out_valid_r;
  logic       mux_bank_r;
  logic [2:0] mux_chan_r;
  logic       res_valid_r;
  logic [1:0] grp_idx_r;
  logic [4:0] csize_r;
  logic [7:0] cbeacon_r;
  logic [4:0] bearing_r;
  logic [MASK_W-1:0] omask_r;

  assign sts.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_res || (cmd.take && !sts.group_end)) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_res) begin
      mux_bank_r  <= pend_bank_r;
      mux_chan_r  <= pend_chan_r;
      res_valid_r <= 1'b1;
      grp_idx_r   <= 2'(proc_grp_r);
      csize_r     <= 5'(best_r);
      cbeacon_r   <= (best_r != '0) ? bid_r : '0;
      bearing_r   <= 5'(brg_c);
      omask_r     <= mask_r;
    end else if (cmd.take && !sts.group_end) begin
      mux_bank_r  <= bank_now;
      mux_chan_r  <= chan_now;
      res_valid_r <= 1'b0;
      grp_idx_r   <= '0;
      csize_r     <= '0;
      cbeacon_r   <= '0;
      bearing_r   <= '0;
      omask_r     <= '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_mux_bank       = mux_bank_r;
  assign out_mux_channel    = mux_chan_r;
  assign out_result_valid   = res_valid_r;
  assign out_group_index    = grp_idx_r;
  assign out_cluster_size   = csize_r;
  assign out_cluster_beacon = cbeacon_r;
  assign out_bearing        = bearing_r;
  assign out_match_mask     = omask_r;

endmodule

`default_nettype wire

// File: test/ir_beacon_slot_bearing_finder_checker.sv
// ----------------------------------------------------------------------------
// ir_beacon_slot_bearing_finder_checker
// Watches the slot, result and register ports of the bearing finder. Keeps
// its own slot frame, work ring and beacon ids, works out the word each
// accepted slot must produce and compares every result word field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ir_beacon_slot_bearing_finder_checker
  import irbsf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [7:0]           in_received_byte,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 out_mux_bank,
  input  logic [2:0]           out_mux_channel,
  input  logic                 out_result_valid,
  input  logic [1:0]           out_group_index,
  input  logic [4:0]           out_cluster_size,
  input  logic [7:0]           out_cluster_beacon,
  input  logic [4:0]           out_bearing,
  input  logic [15:0]          out_match_mask,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  output int                   open_words,
  output int                   fail_count,
  output int                   words_seen,
  output int                   groups_seen
);

  typedef struct packed {
    logic        mux_bank;
    logic [2:0]  mux_channel;
    logic        result_valid;
    logic [1:0]  group_index;
    logic [4:0]  cluster_size;
    logic [7:0]  cluster_beacon;
    logic [4:0]  bearing;
    logic [15:0] match_mask;
  } slot_word_t;

  // slot position to receiver, receiver to analog channel
  localparam logic [3:0] RCV_OF_SLOT [16] =
    '{4'd13, 4'd9, 4'd5, 4'd1, 4'd12, 4'd8, 4'd4, 4'd0,
      4'd15, 4'd11, 4'd7, 4'd3, 4'd14, 4'd10, 4'd6, 4'd2};
  localparam logic [2:0] CHAN_OF_RCV [16] =
    '{3'd2, 3'd5, 3'd3, 3'd2, 3'd7, 3'd1, 3'd7, 3'd1,
      3'd6, 3'd0, 3'd6, 3'd0, 3'd4, 3'd3, 3'd4, 3'd5};

  logic [7:0] id_a;
  logic [7:0] id_b;
  int         slot_pos;
  logic [7:0] frame [FRAME_SLOTS];
  logic [7:0] ring [RING_LEN];
  slot_word_t bearing_q [$];

  initial begin
    open_words  = 0;
    fail_count  = 0;
    words_seen  = 0;
    groups_seen = 0;
  end

  // store one slot, advance the frame and build the word it yields
  function automatic slot_word_t take_slot(input logic [7:0] b);
    slot_word_t w;
    logic [3:0] rcv;
    logic [7:0] v, tag, best_tag, centre, want;
    int         grp, prv, nxt, len, best_len;

    frame[slot_pos] = (b != 8'd0 && (b == id_a || b == id_b)) ? b : 8'd0;
    slot_pos = (slot_pos + 1) % FRAME_SLOTS;
    rcv = RCV_OF_SLOT[slot_pos % RECEIVERS];
    w = '0;
    w.mux_bank    = ~rcv[1];
    w.mux_channel = CHAN_OF_RCV[rcv];
    if (slot_pos % RECEIVERS == 0) begin
      grp = (slot_pos == 0) ? NGROUPS - 1 : slot_pos / RECEIVERS - 1;
      // copy the group, first half repeated at the tail
      for (int i = 0; i < RECEIVERS; i++) begin
        ring[i] = frame[grp * RECEIVERS + i];
      end
      for (int i = 0; i < RECEIVERS / 2; i++) begin
        ring[i + RECEIVERS] = ring[i];
      end
      // in-place gap fill, neighbours wrap circularly
      for (int i = 0; i < RING_LEN; i++) begin
        prv = (i == 0) ? RECEIVERS - 1 : i - 1;
        nxt = (i == RING_LEN - 1) ? RECEIVERS / 2 : i + 1;
        if (ring[prv] == ring[nxt]) begin
          ring[i] = ring[prv];
        end
      end
      // longest run, first one wins ties; a zero past the end closes the last
      len = 0;
      tag = 8'd0;
      best_len = 0;
      best_tag = 8'd0;
      centre = 8'd0;
      for (int i = 0; i <= RING_LEN; i++) begin
        v = (i < RING_LEN) ? ring[i] : 8'd0;
        if (len != 0 && v != tag) begin
          if (len > best_len) begin
            best_len = len;
            best_tag = tag;
            centre = 8'(2 * i - len);
          end
          len = 0;
        end
        if (v != 8'd0) begin
          if (len == 0) begin
            tag = v;
          end
          len++;
        end
      end
      centre = centre - 8'd1;
      if (centre >= 8'(2 * RECEIVERS)) begin
        centre = centre - 8'(2 * RECEIVERS);
      end
      if (centre > 8'(2 * RECEIVERS)) begin
        centre = 8'd0;
      end
      if (grp < 2) begin
        want = (grp == 0) ? id_a : id_b;
        for (int i = 0; i < RECEIVERS; i++) begin
          if (ring[i] == want) begin
            w.match_mask[i] = 1'b1;
          end
        end
      end
      w.result_valid   = 1'b1;
      w.group_index    = grp[1:0];
      w.cluster_size   = best_len[4:0];
      w.cluster_beacon = (best_len != 0) ? best_tag : 8'd0;
      w.bearing        = centre[4:0];
    end
    return w;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s expected %0d got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // follow register writes, slots in and words out
  always @(posedge clk) begin
    slot_word_t w;
    if (!rst_n) begin
      id_a = ID_A_RESET;
      id_b = ID_B_RESET;
      slot_pos = 0;
      bearing_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_ID_A) begin
          id_a = cfg_data;
        end else if (cfg_index == REG_ID_B) begin
          id_b = cfg_data;
        end
      end
      if (in_valid && !in_stall) begin
        bearing_q.push_back(take_slot(in_received_byte));
      end
      if (out_valid && !out_stall) begin
        if (bearing_q.size() == 0) begin
          $error("result word with no slot pending");
          fail_count++;
        end else begin
          w = bearing_q.pop_front();
          words_seen++;
          if (w.result_valid) begin
            groups_seen++;
          end
          check_field("mux_bank", w.mux_bank, out_mux_bank);
          check_field("mux_channel", w.mux_channel, out_mux_channel);
          check_field("result_valid", w.result_valid, out_result_valid);
          check_field("group_index", w.group_index, out_group_index);
          check_field("cluster_size", w.cluster_size, out_cluster_size);
          check_field("cluster_beacon", w.cluster_beacon, out_cluster_beacon);
          check_field("bearing", w.bearing, out_bearing);
          check_field("match_mask", w.match_mask, out_match_mask);
        end
      end
    end
    open_words <= bearing_q.size();
  end

endmodule

// File: test/ir_beacon_slot_bearing_finder_top_tb.sv
// ----------------------------------------------------------------------------
// ir_beacon_slot_bearing_finder_top_tb
// Drives slot bytes into the bearing finder under several beacon id settings,
// with random gaps on the slot side and random stalls on the result side,
// one long result hold-off and one calm phase. The checker beside the block
// predicts and compares every result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ir_beacon_slot_bearing_finder_top_tb;
  import irbsf_pkg::*;

  localparam int PHASE_SLOTS = 205;
  localparam int HOLD_CYCLES = 600;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_received_byte = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_mux_bank;
  logic [2:0] out_mux_channel;
  logic       out_result_valid;
  logic [1:0] out_group_index;
  logic [4:0] out_cluster_size;
  logic [7:0] out_cluster_beacon;
  logic [4:0] out_bearing;
  logic [15:0] out_match_mask;
  logic       cfg_we = 1'b0;
  cfg_reg_t   cfg_index = REG_ID_A;
  logic [7:0] cfg_data = 8'd0;

  int open_words, fail_count, words_seen, groups_seen;

  // stimulus state
  logic [7:0] cur_a = ID_A_RESET;
  logic [7:0] cur_b = ID_B_RESET;
  logic [7:0] run_tag = 8'd0;
  int         run_left = 0;
  bit         run_noise = 1'b0;
  logic       calm = 1'b0;
  logic       squeeze = 1'b0;
  int         hold_left = 0;
  bit         squeezed = 1'b0;

  // group 0 with a lone gap, a rejected byte inside a run and a stray byte,
  // then a run of four of id b and a run of three of id a
  localparam logic [7:0] OPENING [24] =
    '{8'h44, 8'h44, 8'h00, 8'h44, 8'h25, 8'h25, 8'h25, 8'hFF,
      8'h25, 8'h44, 8'h44, 8'h44, 8'h00, 8'h00, 8'h25, 8'h01,
      8'h25, 8'h25, 8'h25, 8'h25, 8'h44, 8'h44, 8'h44, 8'h80};

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  ir_beacon_slot_bearing_finder_top DUT (
    .clk, .rst_n, .in_valid, .in_stall, .in_received_byte,
    .out_valid, .out_stall, .out_mux_bank, .out_mux_channel,
    .out_result_valid, .out_group_index, .out_cluster_size,
    .out_cluster_beacon, .out_bearing, .out_match_mask,
    .cfg_we, .cfg_index, .cfg_data
  );

  ir_beacon_slot_bearing_finder_checker u_checker (
    .clk, .rst_n, .in_valid, .in_stall, .in_received_byte,
    .out_valid, .out_stall, .out_mux_bank, .out_mux_channel,
    .out_result_valid, .out_group_index, .out_cluster_size,
    .out_cluster_beacon, .out_bearing, .out_match_mask,
    .cfg_we, .cfg_index, .cfg_data,
    .open_words, .fail_count, .words_seen, .groups_seen
  );

  // result side: random stalls, one long hold-off, none while calm
  always @(posedge clk) begin
    if (squeeze && !squeezed) begin
      hold_left = HOLD_CYCLES;
      squeezed = 1'b1;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 19);
    end
  end

  // runs of one id with random length, sprinkled with gaps and stray bytes
  function automatic logic [7:0] next_slot_byte();
    int pick;
    if (run_left == 0) begin
      run_left = $urandom_range(1, 12);
      pick = $urandom_range(0, 9);
      run_noise = (pick == 9);
      run_tag = (pick < 4) ? cur_a : (pick < 8) ? cur_b : 8'd0;
    end
    run_left--;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      return 8'd0;
    end else if (pick < 14 || run_noise) begin
      return 8'($urandom_range(0, 255));
    end
    return run_tag;
  endfunction

  task automatic send_word(input logic [7:0] b);
    if (!calm && $urandom_range(0, 99) < 19) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_received_byte <= b;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain(input int tail);
    int guard;
    in_valid <= 1'b0;
    for (guard = 0; open_words != 0 && guard < 50000; guard++) begin
      @(posedge clk);
    end
    repeat (tail) @(posedge clk);
  endtask

  task automatic load_ids(input logic [7:0] a, input logic [7:0] b);
    cfg_we <= 1'b1;
    cfg_index <= REG_ID_A;
    cfg_data <= a;
    @(posedge clk);
    cfg_index <= REG_ID_B;
    cfg_data <= b;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_a = a;
    cur_b = b;
  endtask

  task automatic run_phase(input logic [7:0] a, input logic [7:0] b,
                           input logic quiet, input logic hold);
    drain(8);
    calm <= quiet;
    squeeze <= hold;
    load_ids(a, b);
    repeat (PHASE_SLOTS) send_word(next_slot_byte());
  endtask

  // watchdog
  initial begin
    #5_000_000;
    $display("ir_beacon_slot_bearing_finder_top verification failed");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset ids, directed opening then random slots
    foreach (OPENING[i]) send_word(OPENING[i]);
    repeat (PHASE_SLOTS) send_word(next_slot_byte());

    // zero id, all-ones id, swapped, calm stretch, equal ids, random ids
    run_phase(8'h00, 8'hFF, 1'b0, 1'b0);
    run_phase(8'hFF, 8'h00, 1'b0, 1'b1);
    run_phase(8'h01, 8'h80, 1'b1, 1'b0);
    run_phase(8'h5A, 8'h5A, 1'b0, 1'b0);
    run_phase(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)), 1'b0, 1'b0);

    drain(80);
    $display("covered %0d slot words, %0d group results, over six beacon id settings",
             words_seen, groups_seen);
    $display("settings include zero, all-ones and equal ids, a long result hold-off");
    if (fail_count == 0 && open_words == 0) begin
      $display("ir_beacon_slot_bearing_finder_top verification clean");
    end else begin
      $display("ir_beacon_slot_bearing_finder_top verification failed");
    end
    $finish;
  end

endmodule
